// ----- rtl/tliu_pkg.sv -----
`default_nettype none

package tliu_pkg;

  // Opcodes of an input item.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BELOW = 3'd1;
  localparam logic [2:0] ST_ABOVE = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // Serial divider widths. The dividend magnitude is a product of a positive
  // 16-bit angle span and a 17-bit value span, so it stays below 2**32.
  // The quotient is always smaller than the value span.
  localparam int DVD_W = 32;
  localparam int DSR_W = 16;
  localparam int QUO_W = 17;

  // One table point as it is kept in the memory.
  typedef struct packed {
    logic signed [15:0] ang;
    logic signed [15:0] val;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/tliu_ram.sv -----
`default_nettype none

module tliu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tliu_div.sv -----
`default_nettype none

module tliu_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tliu_pkg::DVD_W-1:0] dividend,
  input  wire logic [tliu_pkg::DSR_W-1:0] divisor,
  output logic                            done,
  output logic      [tliu_pkg::QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(tliu_pkg::DVD_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [tliu_pkg::DVD_W-1:0] work;
  logic [tliu_pkg::DSR_W-1:0] rem;
  logic [tliu_pkg::DSR_W-1:0] dsr;
  logic [tliu_pkg::DSR_W:0]   rem_sh;
  logic [tliu_pkg::DSR_W+1:0] diff;
  logic                       take;

  // One restoring step per cycle; quotient bits shift in where dividend bits leave.
  assign rem_sh   = {rem, work[tliu_pkg::DVD_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr};
  assign take     = ~diff[tliu_pkg::DSR_W+1];
  assign quotient = work[tliu_pkg::QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(tliu_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= take ? diff[tliu_pkg::DSR_W-1:0] : rem_sh[tliu_pkg::DSR_W-1:0];
      work <= {work[tliu_pkg::DVD_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/table_linear_interpolation_unit.sv -----
`default_nettype none

// Piecewise linear lookup table of up to TABLE_DEPTH (angle, value) points in
// Q8.8. Each item clears the table, appends a point (or reports a full table),
// queries a value, or, with the unused opcode, does nothing, and gives exactly
// one result. The block takes one item at a time. A query scans the point
// memory entry by entry up to the first entry at or above the query angle; an
// exact hit ends there, and an interpolation goes on with the multiply, the
// serial divider (load, 32 steps and its done flag) and the final add. The
// first query after loads out of angle order first sorts the table in place.
// A finished result is held in the output register until taken.
module table_linear_interpolation_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  opcode,
  input  wire logic signed [15:0] angle,
  input  wire logic signed [15:0] point_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [15:0] value_out,
  output logic             [2:0]  status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SORT_RDI = 4'd1;
  localparam logic [3:0] S_SORT_LDI = 4'd2;
  localparam logic [3:0] S_SORT_RDJ = 4'd3;
  localparam logic [3:0] S_SORT_CMP = 4'd4;
  localparam logic [3:0] S_SORT_WR1 = 4'd5;
  localparam logic [3:0] S_SORT_WR2 = 4'd6;
  localparam logic [3:0] S_SCAN_RD  = 4'd7;
  localparam logic [3:0] S_SCAN_CMP = 4'd8;
  localparam logic [3:0] S_MUL      = 4'd9;
  localparam logic [3:0] S_DIV_GO   = 4'd10;
  localparam logic [3:0] S_DIV_WAIT = 4'd11;
  localparam logic [3:0] S_SUM      = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0]               state;
  logic [CW-1:0]            count;
  logic                     sorted;
  logic [CW-1:0]            idx_i;
  logic [CW-1:0]            idx_j;
  logic [CW-1:0]            idx_m;
  logic signed [15:0]       q_ang;
  logic signed [15:0]       max_angle;
  tliu_pkg::entry_t         ent_i;
  tliu_pkg::entry_t         min_ent;
  tliu_pkg::entry_t         lo_ent;
  tliu_pkg::entry_t         hi_ent;
  logic signed [33:0]       prod;
  logic [15:0]              span;
  logic                     neg;
  logic signed [15:0]       res_value;
  logic [2:0]               res_status;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  tliu_pkg::entry_t         ram_wdata;
  logic [AW-1:0]            ram_raddr;
  tliu_pkg::entry_t         ram_rdata;

  logic                     in_acc;
  logic                     out_free;
  logic signed [16:0]       dq;
  logic signed [16:0]       dv;
  logic signed [16:0]       da;
  logic signed [33:0]       prod_abs;
  logic                     div_start;
  logic                     div_done;
  logic [tliu_pkg::QUO_W-1:0] div_quo;
  logic signed [17:0]       quo_s;
  logic signed [17:0]       sum;
  logic signed [15:0]       sat;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  tliu_ram #(
    .WIDTH ($bits(tliu_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = '{ang: angle, val: point_value};
    case (state)
      S_IDLE: begin
        ram_we = in_acc && (opcode == tliu_pkg::OP_LOAD) && (count != DEPTH_C);
      end
      S_SORT_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = idx_i[AW-1:0];
        ram_wdata = min_ent;
      end
      S_SORT_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m[AW-1:0];
        ram_wdata = ent_i;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = (state == S_SORT_RDI) ? idx_i[AW-1:0] : idx_j[AW-1:0];

  // Interpolation operands; the angle span is positive and below 2**16.
  assign dq       = {q_ang[15], q_ang} - {lo_ent.ang[15], lo_ent.ang};
  assign dv       = {hi_ent.val[15], hi_ent.val} - {lo_ent.val[15], lo_ent.val};
  assign da       = {hi_ent.ang[15], hi_ent.ang} - {lo_ent.ang[15], lo_ent.ang};
  assign prod_abs = prod[33] ? -prod : prod;
  assign div_start = (state == S_DIV_GO);

  tliu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[tliu_pkg::DVD_W-1:0]),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign quo_s = neg ? -{1'b0, div_quo} : {1'b0, div_quo};
  assign sum   = {{2{lo_ent.val[15]}}, lo_ent.val} + quo_s;

  always_comb begin
    if (sum > 18'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sorted    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (opcode)
              tliu_pkg::OP_CLEAR: begin
                count  <= '0;
                sorted <= 1'b1;
                state  <= S_OUT;
              end
              tliu_pkg::OP_LOAD: begin
                if (count != DEPTH_C) begin
                  // With an ordered table the largest angle is the last one.
                  if (count != '0 && angle < max_angle) begin
                    sorted <= 1'b0;
                  end
                  count <= count + 1'b1;
                end
                state <= S_OUT;
              end
              tliu_pkg::OP_QUERY: begin
                if (count == '0) begin
                  state <= S_OUT;
                end else if (!sorted) begin
                  state <= S_SORT_RDI;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SORT_RDI: state <= S_SORT_LDI;
        S_SORT_LDI: state <= S_SORT_RDJ;
        S_SORT_RDJ: state <= (idx_j == count) ? S_SORT_WR1 : S_SORT_CMP;
        S_SORT_CMP: state <= S_SORT_RDJ;
        S_SORT_WR1: state <= S_SORT_WR2;
        S_SORT_WR2: begin
          if (idx_i + 1'b1 == count) begin
            sorted <= 1'b1;
            state  <= S_SCAN_RD;
          end else begin
            state <= S_SORT_RDI;
          end
        end
        S_SCAN_RD: state <= (idx_j == count) ? S_OUT : S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (ram_rdata.ang == q_ang) begin
            state <= S_OUT;
          end else if (ram_rdata.ang > q_ang) begin
            state <= (idx_j == '0) ? S_OUT : S_MUL;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_MUL:      state <= S_DIV_GO;
        S_DIV_GO:   state <= S_DIV_WAIT;
        S_DIV_WAIT: state <= div_done ? S_SUM : S_DIV_WAIT;
        S_SUM:      state <= S_OUT;
        S_OUT:      state <= out_free ? S_IDLE : S_OUT;
        default:    state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_value  <= '0;
        res_status <= tliu_pkg::ST_OK;
        idx_i      <= '0;
        idx_j      <= '0;
        q_ang      <= angle;
        if (in_acc) begin
          if (opcode == tliu_pkg::OP_LOAD) begin
            if (count == DEPTH_C) begin
              res_status <= tliu_pkg::ST_FULL;
            end else if (count == '0 || angle > max_angle) begin
              max_angle <= angle;
            end
          end else if (opcode == tliu_pkg::OP_QUERY && count == '0) begin
            res_status <= tliu_pkg::ST_EMPTY;
          end
        end
      end
      S_SORT_LDI: begin
        ent_i   <= ram_rdata;
        min_ent <= ram_rdata;
        idx_m   <= idx_i;
        idx_j   <= idx_i + 1'b1;
      end
      S_SORT_CMP: begin
        // Strict compare keeps the first minimum of the pass.
        if (ram_rdata.ang < min_ent.ang) begin
          min_ent <= ram_rdata;
          idx_m   <= idx_j;
        end
        idx_j <= idx_j + 1'b1;
      end
      S_SORT_WR2: begin
        idx_i <= idx_i + 1'b1;
        idx_j <= '0;
      end
      S_SCAN_RD: begin
        if (idx_j == count) begin
          res_status <= tliu_pkg::ST_ABOVE;
        end
      end
      S_SCAN_CMP: begin
        if (ram_rdata.ang == q_ang) begin
          res_value <= ram_rdata.val;
        end else if (ram_rdata.ang > q_ang) begin
          hi_ent <= ram_rdata;
          if (idx_j == '0) begin
            res_status <= tliu_pkg::ST_BELOW;
          end
        end else begin
          lo_ent <= ram_rdata;
          idx_j  <= idx_j + 1'b1;
        end
      end
      S_MUL: begin
        prod <= dq * dv;
        span <= da[15:0];
        neg  <= dv[16];
      end
      S_SUM: begin
        res_value <= sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      value_out <= res_value;
      status    <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("point count exceeds table depth");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_sort_write_range: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_IDLE) |-> {1'b0, ram_waddr} < {1'b0, count})
    else $error("sort writes beyond the filled part of the table");

  a_scan_sorted: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_RD |-> sorted)
    else $error("scan started on an unordered table");

  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == tliu_pkg::OP_QUERY && count == '0)
      |=> (state == S_OUT && res_status == tliu_pkg::ST_EMPTY))
    else $error("query on an empty table not flagged");
`endif

endmodule

`default_nettype wire

// ----- dv/tliu_result_checker.sv -----
`timescale 1ns / 100ps

module tliu_result_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic        [1:0]  opcode,
  input  wire logic signed [15:0] angle,
  input  wire logic signed [15:0] point_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [15:0] value_out,
  input  wire logic        [2:0]  status,
  output int                      errors,
  output int                      pending,
  output int                      checked,
  output int                      sorts,
  output int                      interps,
  output logic             [4:0]  status_seen
);

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic signed [15:0] value;
    logic        [2:0]  status;
  } answer_t;

  answer_t answers_due[$];

  logic signed [15:0] pt_angle [TABLE_DEPTH];
  logic signed [15:0] pt_value [TABLE_DEPTH];
  int n_points;
  bit in_order;
  int reported;

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    sorts = 0;
    interps = 0;
    status_seen = '0;
    reported = 0;
    n_points = 0;
    in_order = 1'b1;
  end

  // Selection sort that swaps each position with the first minimum after it.
  // It is not stable, so duplicate angles must land exactly where it puts them.
  task automatic order_points();
    int i, j, m;
    logic signed [15:0] t;
    for (i = 0; i < n_points; i++) begin
      m = i;
      for (j = i + 1; j < n_points; j++) begin
        if (pt_angle[j] < pt_angle[m]) m = j;
      end
      t = pt_angle[i]; pt_angle[i] = pt_angle[m]; pt_angle[m] = t;
      t = pt_value[i]; pt_value[i] = pt_value[m]; pt_value[m] = t;
    end
    in_order = 1'b1;
    sorts++;
  endtask

  task automatic lookup_value(input logic signed [15:0] q, output logic signed [15:0] v,
                              output logic [2:0] st);
    int i, lo;
    bit have_lo;
    longint a, c, va, vc, r;
    v = '0;
    st = tliu_pkg::ST_OK;
    lo = 0;
    have_lo = 1'b0;
    if (n_points == 0) begin
      st = tliu_pkg::ST_EMPTY;
      return;
    end
    if (!in_order) order_points();
    for (i = 0; i < n_points; i++) begin
      if (pt_angle[i] == q) begin
        v = pt_value[i];
        return;
      end
      if (q > pt_angle[i]) begin
        lo = i;
        have_lo = 1'b1;
      end
    end
    if (!have_lo) begin
      st = tliu_pkg::ST_BELOW;
      return;
    end
    if (lo + 1 >= n_points) begin
      st = tliu_pkg::ST_ABOVE;
      return;
    end
    a = pt_angle[lo];
    c = pt_angle[lo + 1];
    va = pt_value[lo];
    vc = pt_value[lo + 1];
    // Multiply first, then divide; longint division truncates toward zero.
    r = va + ((longint'(q) - a) * (vc - va)) / (c - a);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    v = r[15:0];
    interps++;
  endtask

  task automatic apply_item(input logic [1:0] op, input logic signed [15:0] ang,
                            input logic signed [15:0] pval, output answer_t ans);
    logic signed [15:0] v;
    logic [2:0] st;
    v = '0;
    st = tliu_pkg::ST_OK;
    case (op)
      tliu_pkg::OP_CLEAR: begin
        n_points = 0;
        in_order = 1'b1;
      end
      tliu_pkg::OP_LOAD: begin
        if (n_points >= TABLE_DEPTH) begin
          st = tliu_pkg::ST_FULL;
        end else begin
          if (n_points > 0 && ang < pt_angle[n_points - 1]) in_order = 1'b0;
          pt_angle[n_points] = ang;
          pt_value[n_points] = pval;
          n_points++;
        end
      end
      tliu_pkg::OP_QUERY: begin
        lookup_value(ang, v, st);
      end
      default: begin
      end
    endcase
    ans.value = v;
    ans.status = st;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      n_points = 0;
      in_order = 1'b1;
      answers_due.delete();
      pending = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_item(opcode, angle, point_value, want);
        answers_due = {answers_due, want};
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (answers_due.size() == 0) begin
          errors++;
          if (reported < REPORT_CAP)
            $display("%0t: unexpected result: expected none, got value_out %0d status %0d",
                     $time, value_out, status);
          reported++;
        end else begin
          want = answers_due.pop_front();
          status_seen[want.status] = 1'b1;
          if (value_out !== want.value || status !== want.status) begin
            errors++;
            if (reported < REPORT_CAP)
              $display("%0t: mismatch: expected %0d status %0d, got %0d status %0d",
                       $time, want.value, want.status, value_out, status);
            reported++;
          end
        end
        if (reported == REPORT_CAP + 1)
          $display("%0t: further mismatch reports suppressed", $time);
      end
      pending = answers_due.size();
    end
  end

endmodule

// ----- dv/tb_table_linear_interpolation_unit.sv -----
`timescale 1ns / 100ps

module tb_table_linear_interpolation_unit;

  localparam int TABLE_DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] opcode = tliu_pkg::OP_CLEAR;
  logic signed [15:0] angle = '0;
  logic signed [15:0] point_value = '0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire signed [15:0] value_out;
  wire [2:0] status;

  int errors, pending, checked, sorts, interps;
  logic [4:0] status_seen;

  int items_sent = 0;
  int table_items = 0;
  int cycles = 0;
  bit sender_quiet = 1'b0;
  bit hold_done = 1'b0;
  int loaded_angles[$];

  always #5 clk = ~clk;

  table_linear_interpolation_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .angle(angle), .point_value(point_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .value_out(value_out), .status(status)
  );

  tliu_result_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .angle(angle), .point_value(point_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .value_out(value_out), .status(status),
    .errors(errors), .pending(pending), .checked(checked),
    .sorts(sorts), .interps(interps), .status_seen(status_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int clamp_angle(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_angle(int lo, int width);
    return clamp_angle(lo + int'($urandom_range(0, width)));
  endfunction

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic send_item(input logic [1:0] op, input int ang, input int pval);
    int gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    angle <= ang[15:0];
    point_value <= pval[15:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op != OP_UNUSED) table_items++;
    if (op == tliu_pkg::OP_CLEAR) loaded_angles.delete();
    if (op == tliu_pkg::OP_LOAD) loaded_angles = {loaded_angles, clamp_angle(ang)};
  endtask

  // One table's life: usually a clear, a batch of loads, then queries with
  // the odd extra load mixed in so the table may have to be reordered again.
  task automatic run_table_session(input bit big);
    int npts, nq, lo, width, step, a, k, pick;
    bit ordered;
    if ($urandom_range(0, 4) != 0) send_item(tliu_pkg::OP_CLEAR, rand_value(), rand_value());
    npts = big ? $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6) : $urandom_range(1, 10);
    if ($urandom_range(0, 2) == 0) begin
      lo = -32768;
      width = 65535;
    end else begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      width = $urandom_range(1, 300);
    end
    ordered = ($urandom_range(0, 2) == 0);
    step = width / npts + 1;
    a = clamp_angle(lo);
    for (k = 0; k < npts; k++) begin
      if (ordered) begin
        if (k > 0) a = clamp_angle(a + int'($urandom_range(0, step)));
      end else begin
        a = rand_angle(lo, width);
      end
      send_item(tliu_pkg::OP_LOAD, a, rand_value());
    end
    nq = $urandom_range(2, 10);
    for (k = 0; k < nq; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        send_item(tliu_pkg::OP_LOAD, rand_angle(lo, width), rand_value());
      else if (pick <= 3 && loaded_angles.size() > 0)
        send_item(tliu_pkg::OP_QUERY,
                  loaded_angles[$urandom_range(0, loaded_angles.size() - 1)],
                  rand_value());
      else if (pick == 4)
        send_item(tliu_pkg::OP_QUERY, $urandom_range(0, 1) ? -32768 : 32767, rand_value());
      else
        send_item(tliu_pkg::OP_QUERY, rand_angle(lo - 2, width + 4), rand_value());
    end
  endtask

  // Result side: random stalls, quiet stretches, and one long hold-off while
  // the sender keeps offering items.
  initial begin
    int stall_len, run_len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && checked >= 150) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
    end
  end

  initial begin
    int target, session, n, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, ignored opcode, out-of-order loads with extreme
    // angles and values and a duplicate angle, exact hits, interpolation,
    // below and above the ends, clear.
    send_item(tliu_pkg::OP_QUERY, 0, 0);
    send_item(OP_UNUSED, -32768, 32767);
    send_item(tliu_pkg::OP_LOAD, 100, 1000);
    send_item(tliu_pkg::OP_LOAD, -32768, 32767);
    send_item(tliu_pkg::OP_LOAD, 32767, -32768);
    send_item(tliu_pkg::OP_LOAD, 100, -5);
    send_item(tliu_pkg::OP_LOAD, -256, 0);
    send_item(tliu_pkg::OP_QUERY, -32768, 0);
    send_item(tliu_pkg::OP_QUERY, 32767, 0);
    send_item(tliu_pkg::OP_QUERY, 100, 0);
    send_item(tliu_pkg::OP_QUERY, 50, 0);
    send_item(tliu_pkg::OP_QUERY, 20000, 0);
    send_item(tliu_pkg::OP_QUERY, -30000, 0);
    send_item(OP_UNUSED, 32767, -32768);
    send_item(tliu_pkg::OP_CLEAR, 32767, -1);
    send_item(tliu_pkg::OP_QUERY, 0, -1);
    send_item(tliu_pkg::OP_LOAD, 0, 32767);
    send_item(tliu_pkg::OP_LOAD, 1, -32768);
    send_item(tliu_pkg::OP_QUERY, -1, 0);
    send_item(tliu_pkg::OP_QUERY, 2, 0);
    send_item(tliu_pkg::OP_QUERY, 0, 0);
    send_item(tliu_pkg::OP_LOAD, 32767, 32767);
    send_item(tliu_pkg::OP_QUERY, 16384, 0);
    send_item(tliu_pkg::OP_QUERY, -32768, 0);

    // Random: mostly whole table sessions, some loose noise items. The fourth
    // session, unless it is noise, is a big one that can overfill the table.
    target = table_items + RANDOM_ITEMS;
    session = 0;
    while (table_items < target) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
          send_item(2'($urandom_range(0, 3)), rand_value(), rand_value());
      end else begin
        run_table_session(session == 3 || $urandom_range(0, 19) == 0);
      end
      session++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d sessions; %0d checked, %0d interpolated, %0d sorts.",
             items_sent, session, checked, interps, sorts);
    $display("Status codes seen (one bit per code, ok at right): %b", status_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d results were wrong.", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tliu_pkg.sv
rtl/tliu_ram.sv
rtl/tliu_div.sv
rtl/table_linear_interpolation_unit.sv
dv/tliu_result_checker.sv
dv/tb_table_linear_interpolation_unit.sv
